// ===== hw/rtl/bccf_pkg.sv =====
// Shared constants and types for the boot code checksum frame block.
// No dependencies.
package bccf_pkg;
  localparam logic [31:0] SEED_BASE = 32'h6c078965;
  localparam logic [31:0] MIX_BASE  = 32'h000003EF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // frame memory write request
  typedef struct packed {
    logic        we;
    logic [3:0]  addr;
    logic [31:0] data;
  } fwr_t;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} >> s;
    return d[31:0];
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} << s;
    return d[63:32];
  endfunction
endpackage

// ===== hw/rtl/boot_code_checksum_frame_top.sv =====
// Boot code checksum frame: top level with sequencer, frame memory and mix unit.
// Depends on bccf_pkg, bccf_frame_ram, bccf_mix.
//
// Each code word is processed by a microcoded sequence over a 16-entry frame
// memory (registered read) and one shared registered multiplier. The first
// word of a frame seeds all 16 memory entries and then runs the first update;
// a later word runs the second update for the previous word and then the
// first update. Each micro-op steps through a read, a read-wait and a
// write-back state, plus a multiply state when it mixes; the F9 op mixes only
// when the prior word is below the current one. Only one word is in flight.
// On a word flagged last the 16 frame words leave one per accepted output
// item (slot 0..15), after which the frame is cleared by a sweep over all 16
// entries before the next word is taken. After reset the frame is also
// cleared by that sweep. The seed register may be written at any idle time.
module boot_code_checksum_frame_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] code_word,
  input  logic        is_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] frame_word,
  output logic [3:0]  frame_slot,
  output logic        last_of_frame
);
  import bccf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SEED, S_RD, S_WAIT, S_MUL, S_WB, S_EMIT, S_EWAIT}
    state_t;
  state_t state;

  logic [7:0]  seed_mult;
  logic [31:0] w, prev, pprev, nxt;
  logic [15:0] word_count;
  logic        last;
  logic [5:0]  op;       // micro-op number
  logic [4:0]  cnt;
  logic [31:0] f3new, f4new, f8val, tmp;
  logic        clr; // seeding sweep used as clear

  fwr_t        wr;
  logic [3:0]  raddr;
  logic [31:0] rdata;
  logic        mstart;
  logic [31:0] ma, mb, mres;
  logic [32:0] mc;

  bccf_frame_ram u_ram (.clk(clk), .wr(wr), .raddr(raddr), .rdata(rdata));
  bccf_mix u_mix (.clk(clk), .start(mstart), .a(ma), .b(mb), .c(mc), .res(mres));

  // loop counts: second update uses i, first i+1
  logic [32:0] lc1, lc2;
  assign lc2 = {17'd0, word_count};
  assign lc1 = lc2 + 33'd1;

  logic [31:0] mask;
  logic [31:0] sm_prod;
  assign sm_prod = SEED_BASE * {24'd0, seed_mult};
  assign mask = sm_prod + 32'd1;

  // micro-ops. Second update ops 0..8, first update ops 9..18.
  // Each op: read frame entry (addr), optionally multiply, then write (S15A, S14A, S8RD do not write).
  localparam logic [5:0] OP_S15A = 6'd0, OP_S15B = 6'd1, OP_S14A = 6'd2, OP_S14B = 6'd3,
    OP_S13 = 6'd4, OP_S10 = 6'd5, OP_S11 = 6'd6, OP_S8RD = 6'd7, OP_S12 = 6'd8,
    OP_F0 = 6'd9, OP_F1 = 6'd10, OP_F2 = 6'd11, OP_F3 = 6'd12, OP_F9 = 6'd13,
    OP_F4 = 6'd14, OP_F7 = 6'd15, OP_F6 = 6'd16, OP_F5 = 6'd17, OP_F8 = 6'd18;

  logic [3:0]  op_addr;
  logic        op_mul;
  logic [31:0] op_a, op_b;
  logic [32:0] op_c;
  logic [31:0] op_wdata;
  logic        op_we;

  // operand and result selection per micro-op
  always_comb begin
    op_addr = 4'd0; op_mul = 1'b0; op_a = rdata; op_b = w; op_c = lc1;
    op_we = 1'b1; op_wdata = rdata;
    case (op)
      OP_S15A: begin op_addr = 4'd15; op_mul = 1'b1; op_b = rotl32(prev, pprev[31:27]);
        op_c = lc2; op_we = 1'b0; end
      OP_S15B: begin op_addr = 4'd15; op_mul = 1'b1; op_a = tmp; op_b = rotl32(nxt, prev[31:27]);
        op_c = lc2; op_wdata = mres; end
      OP_S14A: begin op_addr = 4'd14; op_mul = 1'b1; op_b = rotr32(prev, pprev[4:0]);
        op_c = lc2; op_we = 1'b0; end
      OP_S14B: begin op_addr = 4'd14; op_mul = 1'b1; op_a = tmp; op_b = rotr32(nxt, prev[4:0]);
        op_c = lc2; op_wdata = mres; end
      OP_S13: begin op_addr = 4'd13;
        op_wdata = rdata + rotr32(prev, prev[4:0]) + rotr32(nxt, nxt[4:0]); end
      OP_S10: begin op_addr = 4'd10; op_mul = 1'b1; op_a = rdata + prev; op_b = nxt;
        op_c = lc2; op_wdata = mres; end
      OP_S11: begin op_addr = 4'd11; op_mul = 1'b1; op_a = rdata ^ prev; op_b = nxt;
        op_c = lc2; op_wdata = mres; end
      OP_S8RD: begin op_addr = 4'd8; op_we = 1'b0; end
      OP_S12: begin op_addr = 4'd12; op_wdata = rdata + (f8val ^ prev); end
      OP_F0: begin op_addr = 4'd0; op_mul = 1'b1; op_a = MIX_BASE - lc1[31:0];
        op_wdata = rdata + mres; end
      OP_F1: begin op_addr = 4'd1; op_mul = 1'b1; op_wdata = mres; end
      OP_F2: begin op_addr = 4'd2; op_wdata = rdata ^ w; end
      OP_F3: begin op_addr = 4'd3; op_mul = 1'b1; op_a = w + 32'd5; op_b = SEED_BASE;
        op_wdata = rdata + mres; end
      OP_F9: begin op_addr = 4'd9; op_mul = (prev < w);
        op_wdata = (prev < w) ? mres : rdata + w; end
      OP_F4: begin op_addr = 4'd4; op_wdata = rdata + rotr32(w, prev[4:0]); end
      OP_F7: begin op_addr = 4'd7; op_mul = 1'b1; op_b = rotl32(w, prev[4:0]);
        op_wdata = mres; end
      OP_F6: begin op_addr = 4'd6;
        op_wdata = (w < rdata) ? ((w + lc1[31:0]) ^ (f3new + rdata)) : ((f4new + w) ^ rdata); end
      OP_F5: begin op_addr = 4'd5; op_wdata = rdata + rotl32(w, prev[31:27]); end
      OP_F8: begin op_addr = 4'd8; op_mul = 1'b1; op_b = rotr32(w, prev[31:27]);
        op_wdata = mres; end
      default: begin op_we = 1'b0; end
    endcase
  end

  assign ma = op_a;
  assign mb = op_b;
  assign mc = op_c;
  assign mstart = (state == S_MUL);

  // the sweep writes zeros when clearing and the seeded word otherwise
  always_comb begin
    wr = '0;
    raddr = op_addr;
    case (state)
      S_SEED: begin wr.we = 1'b1; wr.addr = cnt[3:0]; wr.data = clr ? 32'd0 : (w ^ mask); end
      S_WB: begin wr.we = op_we; wr.addr = op_addr; wr.data = op_wdata; end
      S_EMIT, S_EWAIT: raddr = cnt[3:0];
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_EWAIT);
  assign frame_word = rdata;
  assign frame_slot = cnt[3:0];
  assign last_of_frame = (cnt[3:0] == 4'd15);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SEED; cnt <= '0; seed_mult <= 8'd63; word_count <= '0;
      prev <= '0; pprev <= '0; last <= 1'b1; clr <= 1'b1; op <= '0;
    end else begin
      if (cfg_we) seed_mult <= cfg_wdata;
      case (state)
        S_IDLE: if (in_valid) begin
          nxt <= code_word; w <= code_word; last <= is_last_word; clr <= 1'b0;
          if (word_count == 16'd0) begin
            state <= S_SEED; cnt <= '0; prev <= code_word; pprev <= code_word;
          end else begin
            state <= S_RD; op <= OP_S15A; w <= prev;
          end
        end
        S_SEED: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            if (clr) state <= S_IDLE;
            else begin state <= S_RD; op <= OP_F0; end
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: state <= op_mul ? S_MUL : S_WB;
        S_MUL: state <= S_WB;
        S_WB: begin
          if (op == OP_S15A || op == OP_S14A) tmp <= mres;
          if (op == OP_S8RD) f8val <= rdata;
          if (op == OP_F3) f3new <= op_wdata;
          if (op == OP_F4) f4new <= op_wdata;
          if (op == OP_S12) w <= nxt;
          if (op == OP_F8) begin
            pprev <= prev; prev <= w;
            if (word_count != COUNT_MAX) word_count <= word_count + 16'd1;
            if (last) begin state <= S_EMIT; cnt <= '0; end
            else state <= S_IDLE;
          end else begin
            op <= op + 6'd1; state <= S_RD;
          end
        end
        S_EMIT: state <= S_EWAIT;
        S_EWAIT: if (!out_stall) begin
          if (cnt[3:0] == 4'd15) begin
            state <= S_SEED; cnt <= '0; clr <= 1'b1; word_count <= '0;
            prev <= '0; pprev <= '0;
          end else begin
            cnt <= cnt + 5'd1; state <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_out_when_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("output while accepting");
  a_slot_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(frame_slot)))
    else $error("slot moved under stall");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEED) |-> (cnt < 5'd16)) else $error("sweep overrun");
`endif
endmodule

// ===== hw/rtl/bccf_mix.sv =====
// Registered mix unit: one 32x32 multiply, then high minus low, or the low half if that is zero.
// Depends on bccf_pkg.
module bccf_mix (
  input  logic        clk,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [32:0] c,
  output logic [31:0] res
);
  import bccf_pkg::*;
  logic [63:0] prod;
  logic [31:0] d;
  logic [32:0] bb;
  logic [64:0] p65;
  // b replaced by c when zero; c may be 2^16 wide enough, kept 33 bits
  assign bb = (b == 32'd0) ? c : {1'b0, b};
  assign p65 = {33'd0, a} * {32'd0, bb};
  always_ff @(posedge clk) begin
    if (start) prod <= p65[63:0];
  end
  assign d = prod[63:32] - prod[31:0];
  assign res = (d == 32'd0) ? prod[31:0] : d;
endmodule

// ===== hw/rtl/bccf_frame_ram.sv =====
// Sixteen-entry frame memory, one write and one registered read port.
// Depends on bccf_pkg.
module bccf_frame_ram (
  input  logic              clk,
  input  bccf_pkg::fwr_t    wr,
  input  logic [3:0]        raddr,
  output logic [31:0]       rdata
);
  import bccf_pkg::*;
  logic [31:0] mem [16];
  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
    rdata <= mem[raddr];
  end
endmodule
